### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define WEV_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WEV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/wev_pkg.sv
// ---------------------------------------------------------------------------
// wev_pkg
// widths, constants and shared types of the windowed encoder velocity block
// ---------------------------------------------------------------------------
package wev_pkg;

    localparam int ANGLE_W     = 21;
    localparam int TIME_W      = 32;
    localparam int SCALE_W     = 32;
    localparam int VEL_W       = 32;
    localparam int ABS_W       = ANGLE_W;
    localparam int DIFF_W      = ANGLE_W + 2;
    localparam int MAG_W       = ABS_W + SCALE_W;
    localparam int SAMPLE_W    = ANGLE_W + TIME_W;
    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VEL_W + 7) / 8) * 8;
    localparam int DIV_CNT_W   = $clog2(MAG_W + 1);

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_W   = 1;

    localparam logic [REG_IDX_W-1:0] REG_SCALE = 1'b0;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_PRIME   = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd33379422;

    localparam logic signed [DIFF_W-1:0] HALF_TURN = 23'sd1048576;
    localparam logic signed [DIFF_W-1:0] FULL_TURN = 23'sd2097152;

    localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### src/wev_ram.sv
// ---------------------------------------------------------------------------
// wev_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module wev_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/wev_div.sv
// ---------------------------------------------------------------------------
// wev_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module wev_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wev_pkg::MAG_W-1:0]   dividend,
    input  logic [wev_pkg::TIME_W-1:0]  divisor,
    output logic [wev_pkg::MAG_W-1:0]   quotient,
    output wev_pkg::div_stat_t          stat
);

    import wev_pkg::*;

    logic [MAG_W-1:0]     quo_reg, quo_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [TIME_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      trial_sub;
    logic                 ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[MAG_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(MAG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[MAG_W-2:0], ge};
            rem_next = ge ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### src/windowed_encoder_velocity_top.sv
// ---------------------------------------------------------------------------
// windowed_encoder_velocity_top
// moving window encoder velocity: ring of past samples in ram, signed
// q16.16 velocity from angle and time differences over the window
// ---------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata: angle, timestamp; tuser: op
//  m_*       out  m_tvalid/m_tready    tdata: velocity_q16; tuser: saturated
//  apb       in   psel/penable/pready  scale_factor at byte address 0
//
//  prime transfer: no result
//  measure transfer: no new input until the result leaves S_DONE; the result
//  comes through S_READ, S_MUL, S_CHK, the 53 step divider at one quotient bit
//  per cycle and S_DONE, with the divider skipped when dt or the product is zero
//  a finished result waits in the output register while a new item is taken;
//  a second result held behind it stays in the last state and holds off input
//  reset: ring reads as zero through per-entry valid bits, no clearing pass
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_encoder_velocity_top #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wev_pkg::IN_TDATA_W-1:0]      s_tdata,    // angle, timestamp, zero pad
    input  logic                                s_tuser,    // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wev_pkg::OUT_TDATA_W-1:0]     m_tdata,    // velocity_q16
    output logic                                m_tuser,    // saturated
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wev_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [wev_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wev_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    import wev_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   ring_idx_reg, ring_idx_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic [ANGLE_W-1:0] prime_ang_reg, prime_ang_next;
    logic [TIME_W-1:0]  prime_ts_reg, prime_ts_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic               out_valid_reg, out_valid_next;

    logic [ANGLE_W-1:0] ang_reg, ang_next;
    logic [TIME_W-1:0]  ts_reg, ts_next;
    logic [ABS_W-1:0]   abs_reg, abs_next;
    logic               pos_reg, pos_next;
    logic [TIME_W-1:0]  dt_reg, dt_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [VEL_W-1:0]   vel_reg, vel_next;
    logic               sat_reg, sat_next;

    logic                 in_xfer;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 ram_we;
    logic [SAMPLE_W-1:0]  ram_rdata;
    logic [ANGLE_W-1:0]   old_ang;
    logic [TIME_W-1:0]    old_ts;
    logic signed [DIFF_W-1:0] diff_raw;
    logic signed [DIFF_W-1:0] diff_wrap;
    logic signed [DIFF_W-1:0] diff_abs;
    logic                 mag_zero;
    logic                 dt_zero;
    logic                 div_start;
    logic [MAG_W-1:0]     div_quo;
    div_stat_t            div_stat;
    logic [VEL_W-1:0]     res_vel;
    logic                 res_sat;
    logic                 q_gt_min;
    logic                 q_gt_max;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign reg_idx  = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign prdata   = (reg_idx == REG_SCALE) ? scale_reg : '0;

    assign ram_we    = (state_reg == S_READ);
    assign mag_zero  = (mag_reg == '0);
    assign dt_zero   = (dt_reg == '0);
    assign div_start = (state_reg == S_CHK) && !mag_zero && !dt_zero;

    wev_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_idx_reg),
        .wdata ({ts_reg, ang_reg}),
        .raddr (ring_idx_reg),
        .rdata (ram_rdata)
    );

    wev_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (dt_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // old sample, angle difference wrapped to a half turn
    always_comb
    begin
        old_ang  = valid_reg[ring_idx_reg] ? ram_rdata[ANGLE_W-1:0] : prime_ang_reg;
        old_ts   = valid_reg[ring_idx_reg] ? ram_rdata[ANGLE_W +: TIME_W] : prime_ts_reg;
        diff_raw = $signed({2'b00, ang_reg}) - $signed({2'b00, old_ang});
        if (diff_raw > HALF_TURN)
        begin
            diff_wrap = diff_raw - FULL_TURN;
        end
        else if (diff_raw < -HALF_TURN)
        begin
            diff_wrap = diff_raw + FULL_TURN;
        end
        else
        begin
            diff_wrap = diff_raw;
        end
        diff_abs = diff_wrap[DIFF_W-1] ? -diff_wrap : diff_wrap;
    end

    // sign, saturation, zero product and zero dt handling
    always_comb
    begin
        q_gt_min = (|div_quo[MAG_W-1:VEL_W]) || (div_quo[VEL_W-1] && (|div_quo[VEL_W-2:0]));
        q_gt_max = |div_quo[MAG_W-1:VEL_W-1];
        res_vel  = '0;
        res_sat  = 1'b0;
        if (mag_zero)
        begin
            res_sat = dt_zero;
        end
        else if (dt_zero)
        begin
            res_sat = 1'b1;
            res_vel = pos_reg ? VEL_MIN : VEL_MAX;
        end
        else if (pos_reg)
        begin
            res_sat = q_gt_min;
            res_vel = q_gt_min ? VEL_MIN : (VEL_W'(0) - div_quo[VEL_W-1:0]);
        end
        else
        begin
            res_sat = q_gt_max;
            res_vel = q_gt_max ? VEL_MAX : div_quo[VEL_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ring_idx_next  = ring_idx_reg;
        valid_next     = valid_reg;
        prime_ang_next = prime_ang_reg;
        prime_ts_next  = prime_ts_reg;
        scale_next     = scale_reg;
        out_valid_next = out_valid_reg;
        ang_next       = ang_reg;
        ts_next        = ts_reg;
        abs_next       = abs_reg;
        pos_next       = pos_reg;
        dt_next        = dt_reg;
        mag_next       = mag_reg;
        vel_next       = vel_reg;
        sat_next       = sat_reg;

        if (cfg_wr && (reg_idx == REG_SCALE))
        begin
            scale_next = pwdata[SCALE_W-1:0];
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    ang_next = s_tdata[ANGLE_W-1:0];
                    ts_next  = s_tdata[ANGLE_W +: TIME_W];
                    if (s_tuser == OP_PRIME)
                    begin
                        prime_ang_next = s_tdata[ANGLE_W-1:0];
                        prime_ts_next  = s_tdata[ANGLE_W +: TIME_W];
                        valid_next     = '0;
                        ring_idx_next  = '0;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                abs_next = diff_abs[ABS_W-1:0];
                pos_next = !diff_wrap[DIFF_W-1] && (diff_wrap != '0);
                dt_next  = ts_reg - old_ts;
                valid_next[ring_idx_reg] = 1'b1;
                ring_idx_next = (ring_idx_reg == IDX_LAST) ? '0 : ring_idx_reg + 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                mag_next   = abs_reg * scale_reg;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = div_start ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    vel_next       = res_vel;
                    sat_next       = res_sat;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ring_idx_reg  <= '0;
            valid_reg     <= '0;
            prime_ang_reg <= '0;
            prime_ts_reg  <= '0;
            scale_reg     <= SCALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ring_idx_reg  <= ring_idx_next;
            valid_reg     <= valid_next;
            prime_ang_reg <= prime_ang_next;
            prime_ts_reg  <= prime_ts_next;
            scale_reg     <= scale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ang_next;
        ts_reg  <= ts_next;
        abs_reg <= abs_next;
        pos_reg <= pos_next;
        dt_reg  <= dt_next;
        mag_reg <= mag_next;
        vel_reg <= vel_next;
        sat_reg <= sat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(vel_reg);
    assign m_tuser  = sat_reg;

    `WEV_ASSERT_ALWAYS(a_idle_div_free, !s_tready || !div_stat.busy, "input taken while divider busy")
    `WEV_ASSERT_NEXT(a_measure_read, in_xfer && (s_tuser == OP_MEASURE), state_reg == S_READ, "measure transfer did not start ring read")
    `WEV_ASSERT_NEXT(a_prime_clear, in_xfer && (s_tuser == OP_PRIME), (valid_reg == '0) && (ring_idx_reg == '0), "prime transfer did not reset ring")
    `WEV_ASSERT_NEXT(a_done_idle, div_stat.done, state_reg == S_DONE, "divider result not picked up")

endmodule
